[rtl/spq_pkg.sv]
// Package for the sorted priority queue: entry and control types, command,
// status, cell operation and sequencer codes. No dependencies.
package spq_pkg;

  localparam int VALUE_W = 32;
  localparam int PRIO_W  = 16;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_DISPLAY = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT,
    CELL_ROTATE
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_SHOW
  } seq_state_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
  } entry_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t op;
    entry_t   ins;
  } cell_ctrl_t;

endpackage

[rtl/sorted_priority_queue.sv]
// Sorted priority queue top level: chain of spq_cell slots, request sequencer
// and registered result stage. Depends on spq_pkg and spq_cell.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------------------
//   request   | in_valid / in_stall  | command, item_value, item_priority
//   result    | out_valid / out_stall| status, out_value, out_priority,
//             |                      | last_result, fill_level
//
// Enqueue and dequeue update all cells together: every cell decides locally from its
// own priority compare and its neighbours, so a request is taken every cycle
// while the result stage drains and no display runs. Display rotates the chain
// one slot per cycle while results drain, emits the head and keeps the order intact.
// Reset (rst, synchronous) clears the valid bits, the fill count and the
// sequencer; slot data is not reset. A stalled result holds the result register
// and the request side stalls until it frees.
module sorted_priority_queue import spq_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                command,
  input  logic signed [VALUE_W-1:0] item_value,
  input  logic signed [PRIO_W-1:0]  item_priority,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [1:0]                status,
  output logic signed [VALUE_W-1:0] out_value,
  output logic signed [PRIO_W-1:0]  out_priority,
  output logic                      last_result,
  output logic [CW-1:0]             fill_level
);

  // Chain wiring
  entry_t                cell_entry [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;
  logic [CAPACITY-1:0]   cell_go;
  cell_ctrl_t            ctrl;
  entry_t                head;

  // Sequencer registers
  seq_state_t  state, state_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;

  // Result register next values
  logic                      out_valid_next;
  logic [1:0]                status_next;
  logic signed [VALUE_W-1:0] out_value_next;
  logic signed [PRIO_W-1:0]  out_priority_next;
  logic                      last_result_next;

  logic out_free;
  logic accept;
  logic emit;
  logic show_last;

  assign head = cell_entry[0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e, right_e;
    logic   left_v, left_g, right_v;
    if (i == 0) begin : g_first
      assign left_e = '0;
      assign left_v = 1'b0;
      assign left_g = 1'b0;
    end else begin : g_mid_l
      assign left_e = cell_entry[i-1];
      assign left_v = cell_valid[i-1];
      assign left_g = cell_go[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = '0;
      assign right_v = 1'b0;
    end else begin : g_mid_r
      assign right_e = cell_entry[i+1];
      assign right_v = cell_valid[i+1];
    end
    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (left_e),
      .left_valid  (left_v),
      .left_go     (left_g),
      .right_entry (right_e),
      .right_valid (right_v),
      .head_entry  (head),
      .entry       (cell_entry[i]),
      .valid       (cell_valid[i]),
      .go          (cell_go[i])
    );
  end

  // Result stage is free when empty or being taken this cycle.
  assign out_free  = !out_valid || !out_stall;
  assign in_stall  = (state != ST_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign show_last = ((idx + CW'(1)) == count);

  always_comb begin
    state_next        = state;
    count_next        = count;
    idx_next          = idx;
    ctrl.op           = CELL_HOLD;
    ctrl.ins.value    = item_value;
    ctrl.ins.prio     = item_priority;
    emit              = 1'b0;
    status_next       = status;
    out_value_next    = out_value;
    out_priority_next = out_priority;
    last_result_next  = last_result;

    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (command)
            CMD_ENQUEUE: begin
              emit              = 1'b1;
              out_value_next    = '0;
              out_priority_next = '0;
              last_result_next  = 1'b1;
              if (count == CW'(CAPACITY)) begin
                // Drop the request: queue full.
                status_next = STAT_FULL;
              end else begin
                status_next = STAT_OK;
                ctrl.op     = CELL_INSERT;
                count_next  = count + CW'(1);
              end
            end
            CMD_DEQUEUE: begin
              emit             = 1'b1;
              last_result_next = 1'b1;
              if (count == '0) begin
                status_next       = STAT_EMPTY;
                out_value_next    = '0;
                out_priority_next = '0;
              end else begin
                status_next       = STAT_OK;
                out_value_next    = head.value;
                out_priority_next = head.prio;
                ctrl.op           = CELL_SHIFT;
                count_next        = count - CW'(1);
              end
            end
            CMD_DISPLAY: begin
              if (count == '0) begin
                emit              = 1'b1;
                status_next       = STAT_EMPTY;
                out_value_next    = '0;
                out_priority_next = '0;
                last_result_next  = 1'b1;
              end else begin
                state_next = ST_SHOW;
                idx_next   = '0;
              end
            end
            default: begin
              // Unused command: no result.
            end
          endcase
        end
      end
      ST_SHOW: begin
        if (out_free) begin
          // Emit the head and rotate it to the back of the occupied slots.
          emit              = 1'b1;
          status_next       = STAT_OK;
          out_value_next    = head.value;
          out_priority_next = head.prio;
          last_result_next  = show_last;
          ctrl.op           = CELL_ROTATE;
          idx_next          = idx + CW'(1);
          if (show_last) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_free) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      idx       <= idx_next;
      out_valid <= out_valid_next;
    end
  end

  // Result payload: load only when a new result is produced.
  always_ff @(posedge clk) begin
    if (emit) begin
      status       <= status_next;
      out_value    <= out_value_next;
      out_priority <= out_priority_next;
      last_result  <= last_result_next;
      fill_level   <= count_next;
    end
  end

endmodule

[rtl/spq_cell.sv]
// One slot of the sorted chain: holds an entry and its valid bit, and trades
// entries with its neighbours. Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  entry_t     left_entry,
  input  logic       left_valid,
  input  logic       left_go,
  input  entry_t     right_entry,
  input  logic       right_valid,
  input  entry_t     head_entry,
  output entry_t     entry,
  output logic       valid,
  output logic       go
);

  entry_t entry_next;
  logic   valid_next;

  // New entry belongs here or in front: slot empty, or stored priority not above.
  assign go = !valid || ($signed(entry.prio) <= $signed(ctrl.ins.prio));

  always_comb begin
    entry_next = entry;
    valid_next = valid;
    case (ctrl.op)
      CELL_INSERT: begin
        if (left_go) begin
          entry_next = left_entry;
          valid_next = left_valid;
        end else if (go) begin
          entry_next = ctrl.ins;
          valid_next = 1'b1;
        end
      end
      CELL_SHIFT: begin
        entry_next = right_entry;
        valid_next = right_valid;
      end
      CELL_ROTATE: begin
        // Last occupied slot takes the head; the rest move one towards the front.
        if (valid && !right_valid) begin
          entry_next = head_entry;
        end else begin
          entry_next = right_entry;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

[rtl/spq_checker.sv]
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and sorted_priority_queue.
module spq_checker import spq_pkg::*; #(
  parameter int CAPACITY = 16,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [1:0]                status,
  input logic signed [VALUE_W-1:0] out_value,
  input logic signed [PRIO_W-1:0]  out_priority,
  input logic                      last_result,
  input logic [CW-1:0]             fill_level
);

  // Hold a stalled result.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_value) && $stable(status)
      && $stable(out_priority) && $stable(last_result) && $stable(fill_level))
    else $error("stalled result changed");

  a_full_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_FULL |-> fill_level == CW'(CAPACITY) && last_result)
    else $error("full report with queue not full");

  a_empty_level: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> fill_level == '0 && last_result
      && out_value == '0 && out_priority == '0)
    else $error("empty report malformed");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_level <= CW'(CAPACITY) && status != 2'd3)
    else $error("fill level beyond capacity");

endmodule

bind sorted_priority_queue spq_checker #(.CAPACITY(CAPACITY)) u_spq_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .out_value    (out_value),
  .out_priority (out_priority),
  .last_result  (last_result),
  .fill_level   (fill_level)
);

[test/tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_priority_queue: directed and random requests,
// results checked against a shadow of the sorted list. Depends on spq_pkg and the RTL.
module tb;
  import spq_pkg::*;

  localparam int QCAP = 16;
  localparam int FILL_W = $clog2(QCAP + 1);
  // Command code with no meaning to the block: it must produce no result.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int TOTAL_REQUESTS = 460;
  localparam int TAIL_REQUESTS = 50;   // last stretch of the run, with no idling
  localparam int HOLD_AFTER = 60;      // requests taken before the long receiver hold
  localparam int LONG_HOLD = 90;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE_CYCLES = 20;

  typedef enum {PRIO_SPREAD, PRIO_CLUSTER, PRIO_EDGE} prio_style_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic                      drain_first;  // hold until every result is back
  } pq_request_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] value;
    logic signed [PRIO_W-1:0]  prio;
    logic                      last;
    logic [FILL_W-1:0]         fill;
  } pq_result_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [1:0]                command = CMD_ENQUEUE;
  logic signed [VALUE_W-1:0] item_value = '0;
  logic signed [PRIO_W-1:0]  item_priority = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [1:0]                status;
  logic signed [VALUE_W-1:0] out_value;
  logic signed [PRIO_W-1:0]  out_priority;
  logic                      last_result;
  logic [FILL_W-1:0]         fill_level;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sorted_priority_queue #(.CAPACITY(QCAP)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .item_value   (item_value),
    .item_priority(item_priority),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .out_value    (out_value),
    .out_priority (out_priority),
    .last_result  (last_result),
    .fill_level   (fill_level)
  );

  // Shadow of the queue contents, highest priority at index 0.
  entry_t      shadow_slots [QCAP];
  int          shadow_level = 0;
  pq_request_t pending_requests [$];
  pq_result_t  expected_results [$];
  pq_request_t offered;
  int          counted_requests = 0;
  int          n_taken = 0;
  int          gap_left = 0;
  int          tx_odds = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  int          rx_odds = 0;
  int          rx_cycle = 0;
  int          idle_cycles = 0;
  int          errors = 0;
  logic        held_long = 1'b0;
  logic        quiet = 1'b0;
  logic        feed_done = 1'b0;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void push_result(status_t st, entry_t e, logic last);
    pq_result_t r;
    r.status = st;
    r.value  = e.value;
    r.prio   = e.prio;
    r.last   = last;
    r.fill   = FILL_W'(shadow_level);
    expected_results.push_back(r);
  endfunction

  // Apply one accepted request to the shadow list and queue up its results.
  function automatic void predict_queue_results(pq_request_t rq);
    entry_t fresh;
    entry_t head;
    int     pos;
    fresh.value = rq.value;
    fresh.prio  = rq.prio;
    case (rq.cmd)
      CMD_ENQUEUE: begin
        if (shadow_level == QCAP) begin
          // Full: drop the entry, report and leave the list alone.
          push_result(STAT_FULL, '0, 1'b1);
        end else begin
          // Insert ahead of the first entry of lower or equal priority, so the
          // newest of a run of equal priorities goes first.
          pos = 0;
          while (pos < shadow_level && $signed(shadow_slots[pos].prio) > $signed(rq.prio))
            pos++;
          for (int i = shadow_level; i > pos; i--)
            shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[pos] = fresh;
          shadow_level++;
          push_result(STAT_OK, '0, 1'b1);
        end
      end
      CMD_DEQUEUE: begin
        if (shadow_level == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          head = shadow_slots[0];
          for (int i = 1; i < shadow_level; i++)
            shadow_slots[i-1] = shadow_slots[i];
          shadow_level--;
          push_result(STAT_OK, head, 1'b1);
        end
      end
      CMD_DISPLAY: begin
        if (shadow_level == 0) begin
          push_result(STAT_EMPTY, '0, 1'b1);
        end else begin
          // One result per entry, front to back; flag the final one.
          for (int i = 0; i < shadow_level; i++)
            push_result(STAT_OK, shadow_slots[i], i == shadow_level - 1);
        end
      end
      default: ;  // unused code: nothing happens and nothing comes back
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void add_request(logic [1:0] cmd, logic signed [VALUE_W-1:0] v,
                                      logic signed [PRIO_W-1:0] p, logic drain_first);
    pq_request_t rq;
    rq.cmd         = cmd;
    rq.value       = v;
    rq.prio        = p;
    rq.drain_first = drain_first;
    pending_requests.push_back(rq);
    if (cmd != CMD_UNUSED)
      counted_requests++;
  endfunction

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 11))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [PRIO_W-1:0] pick_priority(prio_style_t style);
    case (style)
      PRIO_SPREAD:  return PRIO_W'($urandom);
      // Narrow band around zero: plenty of equal priorities.
      PRIO_CLUSTER: return PRIO_W'(int'($urandom_range(0, 4)) - 2);
      default: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7fff;
          1:       return 16'sh8000;
          2:       return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: offer pending requests, hold while stalled, idle in bursts.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_queue_results(offered);
        n_taken <= n_taken + 1;
      end
      if (in_valid && in_stall) begin
        // Stalled: hold the request and its payload as they are.
      end else if (gap_left > 0 && !quiet) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_requests.size() == 0) begin
        in_valid  <= 1'b0;
        feed_done <= 1'b1;
      end else if (pending_requests[0].drain_first && expected_results.size() != 0) begin
        // Pause the sender until every outstanding result has come back.
        in_valid <= 1'b0;
      end else begin
        offered = pending_requests.pop_front();
        in_valid      <= 1'b1;
        command       <= offered.cmd;
        item_value    <= offered.value;
        item_priority <= offered.prio;
        quiet <= pending_requests.size() < TAIL_REQUESTS;
        // Re-pick the idling rate now and then; zero gives a stretch with none.
        if (pending_requests.size() % 40 == 0)
          tx_odds <= $urandom_range(0, 3);
        if (tx_odds != 0 && $urandom_range(1, 3 * tx_odds) == 1)
          gap_left <= $urandom_range(1, 11);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stall bursts plus one long hold to back the block up.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 100 == 0)
        rx_odds <= $urandom_range(0, 3);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left <= hold_left - 1;
      end else if (!held_long && n_taken >= HOLD_AFTER) begin
        // Long hold while the sender keeps offering: fill the block and stall it.
        out_stall <= 1'b1;
        hold_left <= LONG_HOLD - 1;
        held_long <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        out_stall  <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rx_odds != 0 && $urandom_range(1, 3 * rx_odds) == 1) begin
        out_stall  <= 1'b1;
        stall_left <= $urandom_range(1, 11) - 1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker and activity count for the watchdog.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pq_result_t want;
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d value %0d priority %0d",
                 status, out_value, out_priority);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            errors++;
          end
          if (out_value !== want.value) begin
            $error("out_value: expected %0d, got %0d", want.value, out_value);
            errors++;
          end
          if (out_priority !== want.prio) begin
            $error("out_priority: expected %0d, got %0d", want.prio, out_priority);
            errors++;
          end
          if (last_result !== want.last) begin
            $error("last_result: expected %0d, got %0d", want.last, last_result);
            errors++;
          end
          if (fill_level !== want.fill) begin
            $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
            errors++;
          end
        end
      end
    end
  end

  // Give up when nothing moves on either side for too long.
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int          run_len;
    int          pick;
    prio_style_t style;

    // Directed: empty cases, the unused code, field extremes, equal priorities,
    // then fill to capacity, overflow and a full-length display.
    add_request(CMD_DEQUEUE, 32'sd5, 16'sd5, 1'b0);
    add_request(CMD_DISPLAY, '1, '1, 1'b0);
    add_request(CMD_UNUSED, '1, '1, 1'b0);
    add_request(CMD_ENQUEUE, 32'sh7fffffff, 16'sh7fff, 1'b0);
    add_request(CMD_ENQUEUE, 32'sh80000000, 16'sh8000, 1'b0);
    add_request(CMD_ENQUEUE, '0, '0, 1'b0);
    add_request(CMD_ENQUEUE, '1, '1, 1'b0);
    add_request(CMD_ENQUEUE, 32'sd11, '0, 1'b0);
    add_request(CMD_ENQUEUE, 32'sd12, '0, 1'b0);
    add_request(CMD_DISPLAY, '0, '0, 1'b0);
    add_request(CMD_DEQUEUE, '0, '0, 1'b0);
    add_request(CMD_DEQUEUE, '0, '0, 1'b0);
    for (int i = 0; i < 12; i++)
      add_request(CMD_ENQUEUE, pick_value(), pick_priority(PRIO_SPREAD), 1'b0);
    add_request(CMD_ENQUEUE, 32'sd99, 16'sh7fff, 1'b0);
    add_request(CMD_DISPLAY, '0, '0, 1'b0);

    // Random: runs of enqueues that reach full, runs of dequeues that reach
    // empty, mixed traffic, displays, some noise and the odd drain point.
    add_request(CMD_DISPLAY, pick_value(), pick_priority(PRIO_SPREAD), 1'b1);
    while (counted_requests < TOTAL_REQUESTS) begin
      run_len = $urandom_range(4, 20);
      style   = prio_style_t'($urandom_range(0, 2));
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          for (int i = 0; i < run_len; i++)
            add_request(CMD_ENQUEUE, pick_value(), pick_priority(style), 1'b0);
        end
        3, 4: begin
          for (int i = 0; i < run_len; i++)
            add_request(CMD_DEQUEUE, pick_value(), pick_priority(style), 1'b0);
        end
        5, 6: begin
          for (int i = 0; i < run_len; i++) begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
              add_request(CMD_ENQUEUE, pick_value(), pick_priority(style), 1'b0);
            else if (pick < 16)
              add_request(CMD_DEQUEUE, pick_value(), pick_priority(style), 1'b0);
            else if (pick < 19)
              add_request(CMD_DISPLAY, pick_value(), pick_priority(style), 1'b0);
            else
              add_request(CMD_UNUSED, pick_value(), pick_priority(style), 1'b0);
          end
        end
        7: add_request(CMD_DISPLAY, pick_value(), pick_priority(style), 1'b0);
        8: begin
          for (int i = 0; i < 4; i++)
            add_request(2'($urandom), VALUE_W'($urandom), PRIO_W'($urandom), 1'b0);
        end
        default: add_request(CMD_DISPLAY, pick_value(), pick_priority(style), 1'b1);
      endcase
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (!feed_done) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    // Let any stray result show itself before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
